>>> hdl/bltp_pkg.sv
`timescale 1ns / 1ps

package bltp_pkg;

    localparam int MAX_BYTES  = 8;
    localparam int TEXT_LIMIT = 64;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 3;
    localparam int LEN_W      = $clog2(TEXT_LIMIT);
    localparam int VAL_W      = 9;
    localparam int PROD_W     = 13;
    localparam logic [VAL_W-1:0] VALUE_CAP = 9'd256;
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_PTR_W   = 2;
    localparam int FQ_CNT_W   = 3;
    localparam int RQ_DEPTH   = 2;
    localparam int RQ_CNT_W   = 2;

    // Classified character, one queue word between front and back.
    typedef struct packed {
        logic       last;
        logic       hex;
        logic       nul;
        logic       space;
        logic       plus;
        logic       minus;
        logic       is_x;
        logic       dig_ok;
        logic [3:0] dig;
    } t_cls;

    typedef enum logic [4:0] {
        PH_BETWEEN   = 5'b00001,
        PH_SIGNED    = 5'b00010,
        PH_LEAD_ZERO = 5'b00100,
        PH_PREFIX    = 5'b01000,
        PH_DIGITS    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic                      ok;
        logic [CNT_W-1:0]          count;
        logic [MAX_BYTES-1:0][7:0] bytes;
    } t_res;

endpackage

>>> hdl/bltp_front.sv
`timescale 1ns / 1ps

module bltp_front import bltp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    output t_cls       o_cls,
    input  logic       i_take
);

    logic                r_hex_mode;
    t_cls                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr;
    logic [FQ_PTR_W-1:0] r_rd;
    logic [FQ_CNT_W-1:0] r_cnt;
    t_cls                cls;
    logic                wr_en;
    logic                rd_en;
    logic [7:0]          d_raw;
    logic                d_hit;

    // Classify the character against the current base.
    always_comb begin
        d_raw = 8'd0;
        d_hit = 1'b0;
        if (i_ch >= "0" && i_ch <= "9") begin
            d_raw = i_ch - 8'd48;
            d_hit = 1'b1;
        end else if (i_ch >= "a" && i_ch <= "f") begin
            d_raw = i_ch - 8'd87;
            d_hit = 1'b1;
        end else if (i_ch >= "A" && i_ch <= "F") begin
            d_raw = i_ch - 8'd55;
            d_hit = 1'b1;
        end
        cls.last   = i_last;
        cls.hex    = r_hex_mode;
        cls.nul    = (i_ch == 8'd0);
        cls.space  = (i_ch == 8'd32) || (i_ch >= 8'd9 && i_ch <= 8'd13);
        cls.plus   = (i_ch == "+");
        cls.minus  = (i_ch == "-");
        cls.is_x   = (i_ch == "x") || (i_ch == "X");
        cls.dig_ok = d_hit && (r_hex_mode || d_raw < 8'd10);
        cls.dig    = d_raw[3:0];
    end

    assign o_full  = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_hex_mode <= i_cfg_data;
            end
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cls;
        end
    end

endmodule

>>> hdl/bltp_back.sv
`timescale 1ns / 1ps

module bltp_back import bltp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cls i_cls,
    output logic o_take,
    input  logic i_res_full,
    output logic o_res_valid,
    output t_res o_res
);

    t_phase           r_phase;
    logic [VAL_W-1:0] r_val;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_store [MAX_BYTES];
    logic [LEN_W-1:0] r_chars;
    logic             r_rejected;
    logic             r_ended;

    t_phase           n_phase;
    logic [VAL_W-1:0] n_val;
    logic             n_neg;
    logic [CNT_W-1:0] n_cnt;
    logic [LEN_W-1:0] n_chars;
    logic             n_rejected;
    logic             n_ended;

    logic             step;
    logic             len_rej;
    logic             active;
    logic             term;
    logic             do_end;
    logic             wr;
    logic [7:0]       wr_val;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic [VAL_W-1:0] acc;
    logic             ok;

    always_comb begin
        step    = i_valid && !i_res_full;
        len_rej = (r_chars >= LEN_W'(TEXT_LIMIT - 1));
        n_chars = len_rej ? r_chars : r_chars + 1'b1;

        n_phase    = r_phase;
        n_val      = r_val;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_rejected = r_rejected || len_rej;
        n_ended    = r_ended;
        active     = !n_rejected && !r_ended;
        term       = i_cls.nul || i_cls.space;

        // Saturating accumulate by the item's base.
        prod = i_cls.hex ? {r_val, 4'b0000} : PROD_W'(r_val) * PROD_W'(10);
        sum  = prod + PROD_W'(i_cls.dig);
        acc  = (sum > PROD_W'(VALUE_CAP)) ? VALUE_CAP : sum[VAL_W-1:0];

        if (active && !term) begin
            unique case (r_phase)
                PH_BETWEEN: begin
                    if (r_cnt >= CNT_W'(MAX_BYTES)) begin
                        n_rejected = 1'b1;
                    end else if (i_cls.plus || i_cls.minus) begin
                        n_phase = PH_SIGNED;
                        n_neg   = i_cls.minus;
                    end else if (i_cls.dig_ok) begin
                        n_val   = VAL_W'(i_cls.dig);
                        n_phase = (i_cls.dig == 4'd0) ? PH_LEAD_ZERO : PH_DIGITS;
                    end else begin
                        n_rejected = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    if (i_cls.dig_ok) begin
                        n_val   = VAL_W'(i_cls.dig);
                        n_phase = (i_cls.dig == 4'd0) ? PH_LEAD_ZERO : PH_DIGITS;
                    end else begin
                        n_rejected = 1'b1;
                    end
                end
                PH_LEAD_ZERO: begin
                    if (i_cls.hex && i_cls.is_x) begin
                        n_phase = PH_PREFIX;
                    end else if (i_cls.dig_ok) begin
                        n_val   = acc;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_rejected = 1'b1;
                    end
                end
                PH_PREFIX, PH_DIGITS: begin
                    if (i_cls.dig_ok) begin
                        n_val   = acc;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_rejected = 1'b1;
                    end
                end
                default: begin
                    n_rejected = 1'b1;
                end
            endcase
        end

        // One token end per character: a terminator, or the end of the payload.
        do_end = (active && term) || (i_cls.last && !n_rejected && !r_ended && !term);
        if (active && i_cls.nul) begin
            n_ended = 1'b1;
        end

        wr     = 1'b0;
        wr_val = n_val[7:0];
        if (do_end) begin
            if (n_phase == PH_LEAD_ZERO || n_phase == PH_DIGITS) begin
                if (n_val[8] || (n_neg && n_val != '0) || n_cnt >= CNT_W'(MAX_BYTES)) begin
                    n_rejected = 1'b1;
                end else begin
                    wr    = 1'b1;
                    n_cnt = n_cnt + 1'b1;
                end
            end else if (n_phase != PH_BETWEEN) begin
                n_rejected = 1'b1;
            end
            n_phase = PH_BETWEEN;
            n_val   = '0;
            n_neg   = 1'b0;
        end

        ok          = !n_rejected && (n_cnt != '0);
        o_res.ok    = ok;
        o_res.count = ok ? n_cnt : '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (ok && CNT_W'(i) < n_cnt) begin
                o_res.bytes[i] = (wr && CNT_W'(i) == r_cnt) ? wr_val : r_store[i];
            end else begin
                o_res.bytes[i] = 8'd0;
            end
        end

        o_take      = step;
        o_res_valid = step && i_cls.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BETWEEN;
            r_val      <= '0;
            r_neg      <= 1'b0;
            r_cnt      <= '0;
            r_chars    <= '0;
            r_rejected <= 1'b0;
            r_ended    <= 1'b0;
        end else if (step) begin
            if (i_cls.last) begin
                r_phase    <= PH_BETWEEN;
                r_val      <= '0;
                r_neg      <= 1'b0;
                r_cnt      <= '0;
                r_chars    <= '0;
                r_rejected <= 1'b0;
                r_ended    <= 1'b0;
            end else begin
                r_phase    <= n_phase;
                r_val      <= n_val;
                r_neg      <= n_neg;
                r_cnt      <= n_cnt;
                r_chars    <= n_chars;
                r_rejected <= n_rejected;
                r_ended    <= n_ended;
            end
        end
    end

    // Entries past the count are never read, so the store needs no clearing.
    always_ff @(posedge i_clk) begin
        if (step && wr) begin
            r_store[r_cnt[IDX_W-1:0]] <= wr_val;
        end
    end

endmodule

>>> hdl/bltp_res_queue.sv
`timescale 1ns / 1ps

module bltp_res_queue import bltp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);

    t_res                r_mem [RQ_DEPTH];
    logic                r_wr;
    logic                r_rd;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_cnt == RQ_CNT_W'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

>>> hdl/byte_list_text_parser_unit.sv
`timescale 1ns / 1ps

// Byte-list text parser: turns a text payload, one character per word, into
// up to eight data bytes, read as decimal or hex tokens.
// Input side is a queue: drive i_ch / i_last with push; a word is taken at
// an edge where push is high and full is low. i_last marks the final
// character of a payload.
// Result side is a queue: while empty is low the oldest result (o_ok,
// o_byte_count, o_byte0..7) is on the ports; pop takes it.
// i_cfg_we / i_cfg_data write hex_mode; write it only while the block is idle.
// With nothing queued ahead, the result of a payload shows (empty low) once
// its last character has passed the classify queue: the parser update and
// the result write happen together at the edge that takes the character out.
// Throughput: one character per cycle while the result queue is not full,
// set by the parser state update in the back end; a four-word classify
// queue and a two-word result queue sit on either side of it.
// Reset (synchronous, active low) clears the queues, the parser state and
// hex_mode. If the receiver stalls, results collect in the result queue, the
// parser holds once it is full and the classify queue fills until full rises.
module byte_list_text_parser_unit import bltp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       empty,
    input  logic       pop,
    output logic       o_ok,
    output logic [3:0] o_byte_count,
    output logic [7:0] o_byte0,
    output logic [7:0] o_byte1,
    output logic [7:0] o_byte2,
    output logic [7:0] o_byte3,
    output logic [7:0] o_byte4,
    output logic [7:0] o_byte5,
    output logic [7:0] o_byte6,
    output logic [7:0] o_byte7
);

    logic cls_valid;
    t_cls cls;
    logic cls_take;
    logic res_full;
    logic res_push;
    t_res res_in;
    t_res res_out;

    // Front: classify each character and hold it in a short queue.
    bltp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .o_valid    (cls_valid),
        .o_cls      (cls),
        .i_take     (cls_take)
    );

    // Back: advance the token parser, emit a result on the last character.
    bltp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cls_valid),
        .i_cls       (cls),
        .o_take      (cls_take),
        .i_res_full  (res_full),
        .o_res_valid (res_push),
        .o_res       (res_in)
    );

    // Hold finished results until the receiver pops them.
    bltp_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_ok         = res_out.ok;
    assign o_byte_count = res_out.count;
    assign o_byte0      = res_out.bytes[0];
    assign o_byte1      = res_out.bytes[1];
    assign o_byte2      = res_out.bytes[2];
    assign o_byte3      = res_out.bytes[3];
    assign o_byte4      = res_out.bytes[4];
    assign o_byte5      = res_out.bytes[5];
    assign o_byte6      = res_out.bytes[6];
    assign o_byte7      = res_out.bytes[7];

endmodule
